@@ design/dnes_pkg.sv @@
`timescale 1ns / 1ps

package dnes_pkg;

    localparam int SUM_W = 56;
    localparam int CNT_W = 8;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_INT  = 2'd1,
        PH_FRAC = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_INT  = 2'd1,
        KIND_REAL = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [SUM_W-1:0] total_sum;
        logic [CNT_W-1:0] integer_count;
        logic [CNT_W-1:0] real_count;
    } out_word_t;

endpackage

@@ design/dnes_step.sv @@
`timescale 1ns / 1ps

module dnes_step #(
    parameter int FRAC_BITS       = 24,
    parameter int MAX_FRAC_DIGITS = 7,
    parameter int TOK_W           = 56,
    parameter int FIDX_W          = 3
) (
    input  dnes_pkg::in_word_t               word,
    input  dnes_pkg::phase_t                 phase,
    input  dnes_pkg::kind_t                  kind,
    input  logic [TOK_W-1:0]                 tok,
    input  logic [FIDX_W-1:0]                fidx,
    input  logic [TOK_W-1:0]                 sum,
    input  logic [dnes_pkg::CNT_W-1:0]       icnt,
    input  logic [dnes_pkg::CNT_W-1:0]       rcnt,
    output dnes_pkg::phase_t                 phase_next,
    output dnes_pkg::kind_t                  kind_next,
    output logic [TOK_W-1:0]                 tok_next,
    output logic [FIDX_W-1:0]                fidx_next,
    output logic [TOK_W-1:0]                 sum_next,
    output logic [dnes_pkg::CNT_W-1:0]       icnt_next,
    output logic [dnes_pkg::CNT_W-1:0]       rcnt_next,
    output dnes_pkg::out_word_t              result
);

    localparam int W_DEPTH = 2 ** FIDX_W;
    localparam int PROD_W  = FRAC_BITS + 4;
    localparam logic [TOK_W-1:0] LIM = '1;

    function automatic logic [63:0] pow10(input int k);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    // weight of fraction digit k+1: round(2^F / 10^(k+1)), halves up
    logic [FRAC_BITS-1:0] weight [W_DEPTH];

    for (genvar k = 0; k < W_DEPTH; k++) begin : g_w
        if (k < MAX_FRAC_DIGITS) begin : g_on
            localparam logic [63:0] P = pow10(k + 1);
            localparam logic [63:0] W = ((64'd1 << (FRAC_BITS + 1)) / P + 64'd1) / 64'd2;
            assign weight[k] = W[FRAC_BITS-1:0];
        end else begin : g_off
            assign weight[k] = '0;
        end
    end

    logic                  digit;
    logic                  sep;
    logic [3:0]            d;
    logic [TOK_W+4:0]      int_sum;
    logic [TOK_W-1:0]      int_val;
    logic [PROD_W-1:0]     prod;
    logic [TOK_W:0]        frac_sum;
    logic [TOK_W-1:0]      frac_val;
    logic                  frac_take;

    dnes_pkg::phase_t      p_phase;
    dnes_pkg::kind_t       p_kind;
    logic [TOK_W-1:0]      p_tok;
    logic [FIDX_W-1:0]     p_fidx;
    logic                  end_now;
    logic                  do_end;
    logic [TOK_W:0]        tot_sum;
    logic [TOK_W-1:0]      tot_val;
    logic [TOK_W-1:0]      e_sum;
    logic [dnes_pkg::CNT_W-1:0] e_icnt;
    logic [dnes_pkg::CNT_W-1:0] e_rcnt;

    assign digit = (word.ch >= dnes_pkg::CH_ZERO) && (word.ch <= dnes_pkg::CH_NINE);
    assign sep   = (word.ch == dnes_pkg::CH_DOT) || (word.ch == dnes_pkg::CH_COMMA);
    assign d     = digit ? 4'(word.ch - dnes_pkg::CH_ZERO) : 4'd0;

    // tok*10 + d<<F, saturated
    assign int_sum = (TOK_W+5)'({tok, 3'b000}) + (TOK_W+5)'({tok, 1'b0})
                   + ((TOK_W+5)'(d) << FRAC_BITS);
    assign int_val = (int_sum > (TOK_W+5)'(LIM)) ? LIM : int_sum[TOK_W-1:0];

    assign prod      = PROD_W'(d) * PROD_W'(weight[fidx]);
    assign frac_sum  = (TOK_W+1)'(tok) + (TOK_W+1)'(prod);
    assign frac_val  = (frac_sum > (TOK_W+1)'(LIM)) ? LIM : frac_sum[TOK_W-1:0];
    assign frac_take = fidx < FIDX_W'(MAX_FRAC_DIGITS);

    always_comb
    begin
        p_phase = phase;
        p_kind  = kind;
        p_tok   = tok;
        p_fidx  = fidx;
        end_now = 1'b0;
        unique case (phase)
            dnes_pkg::PH_SKIP:
            begin
                if (digit)
                begin
                    p_phase = dnes_pkg::PH_INT;
                    p_kind  = dnes_pkg::KIND_INT;
                    p_tok   = int_val;
                end
                else if (sep)
                begin
                    p_phase = dnes_pkg::PH_FRAC;
                end
            end
            dnes_pkg::PH_INT:
            begin
                if (digit)
                begin
                    p_tok = int_val;
                end
                else if (sep)
                begin
                    p_phase = dnes_pkg::PH_FRAC;
                end
                else
                begin
                    end_now = 1'b1;
                end
            end
            dnes_pkg::PH_FRAC:
            begin
                if (digit)
                begin
                    p_kind = dnes_pkg::KIND_REAL;
                    if (frac_take)
                    begin
                        p_fidx = fidx + 1'b1;
                        p_tok  = frac_val;
                    end
                end
                else
                begin
                    end_now = 1'b1;
                end
            end
            default:
            begin
                p_phase = dnes_pkg::PH_SKIP;
            end
        endcase
    end

    // ending byte is consumed; an open number is also closed on the last byte
    assign do_end  = end_now || (word.last && (p_phase != dnes_pkg::PH_SKIP));

    assign tot_sum = (TOK_W+1)'(sum) + (TOK_W+1)'(p_tok);
    assign tot_val = (tot_sum > (TOK_W+1)'(LIM)) ? LIM : tot_sum[TOK_W-1:0];

    always_comb
    begin
        e_sum  = sum;
        e_icnt = icnt;
        e_rcnt = rcnt;
        if (do_end)
        begin
            e_sum = tot_val;
            if ((p_kind == dnes_pkg::KIND_INT) && (icnt != dnes_pkg::CNT_MAX))
            begin
                e_icnt = icnt + 1'b1;
            end
            if ((p_kind == dnes_pkg::KIND_REAL) && (rcnt != dnes_pkg::CNT_MAX))
            begin
                e_rcnt = rcnt + 1'b1;
            end
        end
    end

    always_comb
    begin
        phase_next = p_phase;
        kind_next  = p_kind;
        tok_next   = p_tok;
        fidx_next  = p_fidx;
        sum_next   = e_sum;
        icnt_next  = e_icnt;
        rcnt_next  = e_rcnt;
        if (do_end || word.last)
        begin
            phase_next = dnes_pkg::PH_SKIP;
            kind_next  = dnes_pkg::KIND_NONE;
            tok_next   = '0;
            fidx_next  = '0;
        end
        if (word.last)
        begin
            sum_next  = '0;
            icnt_next = '0;
            rcnt_next = '0;
        end
    end

    assign result.total_sum     = dnes_pkg::SUM_W'(e_sum);
    assign result.integer_count = e_icnt;
    assign result.real_count    = e_rcnt;

endmodule

@@ design/decimal_number_extract_sum.sv @@
`timescale 1ns / 1ps

// channel | handshake            | word        | contents
// src     | src_valid/src_stall  | src_data    | ch (8), last (1)
// res     | res_valid/res_stall  | res_data    | total_sum (56), integer_count, real_count
//
// One byte per cycle sustained while src_stall is low. A byte sits in the
// input register, then the scan logic updates the token and sum registers.
// The result is registered from the last byte's step and holds while stalled.
// src stalls only when a last byte waits behind a result that is itself stalled.
// rst_n clears all scan state and both valid flags asynchronously.

module decimal_number_extract_sum #(
    parameter int FRAC_BITS       = 24,
    parameter int MAX_FRAC_DIGITS = 7,
    parameter int INT_BITS        = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  dnes_pkg::in_word_t   src_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output dnes_pkg::out_word_t  res_data
);

    localparam int TOK_W  = (INT_BITS + FRAC_BITS > dnes_pkg::SUM_W) ?
                            dnes_pkg::SUM_W : INT_BITS + FRAC_BITS;
    localparam int FIDX_W = $clog2(MAX_FRAC_DIGITS + 1);

    logic                       s1_valid_reg;
    dnes_pkg::in_word_t         s1_word_reg;

    dnes_pkg::phase_t           phase_reg, phase_next;
    dnes_pkg::kind_t            kind_reg, kind_next;
    logic [TOK_W-1:0]           tok_reg, tok_next;
    logic [FIDX_W-1:0]          fidx_reg, fidx_next;
    logic [TOK_W-1:0]           sum_reg, sum_next;
    logic [dnes_pkg::CNT_W-1:0] icnt_reg, icnt_next;
    logic [dnes_pkg::CNT_W-1:0] rcnt_reg, rcnt_next;

    logic                       res_valid_reg;
    dnes_pkg::out_word_t        res_word_reg;
    dnes_pkg::out_word_t        step_result;

    logic                       fire;
    logic                       src_take;

    // a last byte needs the result register free (or draining this cycle)
    assign fire      = s1_valid_reg && (!s1_word_reg.last || !res_valid_reg || !res_stall);
    assign src_stall = s1_valid_reg && !fire;
    assign src_take  = src_valid && !src_stall;

    dnes_step #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .TOK_W           (TOK_W),
        .FIDX_W          (FIDX_W)
    ) u_step (
        .word       (s1_word_reg),
        .phase      (phase_reg),
        .kind       (kind_reg),
        .tok        (tok_reg),
        .fidx       (fidx_reg),
        .sum        (sum_reg),
        .icnt       (icnt_reg),
        .rcnt       (rcnt_reg),
        .phase_next (phase_next),
        .kind_next  (kind_next),
        .tok_next   (tok_next),
        .fidx_next  (fidx_next),
        .sum_next   (sum_next),
        .icnt_next  (icnt_next),
        .rcnt_next  (rcnt_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= dnes_pkg::PH_SKIP;
            kind_reg      <= dnes_pkg::KIND_NONE;
            tok_reg       <= '0;
            fidx_reg      <= '0;
            sum_reg       <= '0;
            icnt_reg      <= '0;
            rcnt_reg      <= '0;
        end
        else
        begin
            if (src_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                tok_reg   <= tok_next;
                fidx_reg  <= fidx_next;
                sum_reg   <= sum_next;
                icnt_reg  <= icnt_next;
                rcnt_reg  <= rcnt_next;
            end

            if (fire && s1_word_reg.last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_take)
        begin
            s1_word_reg <= src_data;
        end
        if (fire && s1_word_reg.last)
        begin
            res_word_reg <= step_result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_word_reg;

endmodule

@@ design/dnes_checker.sv @@
`timescale 1ns / 1ps

module dnes_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                src_valid,
    input logic                src_stall,
    input dnes_pkg::in_word_t  src_data,
    input logic                res_valid,
    input logic                res_stall,
    input dnes_pkg::out_word_t res_data
);

    // a stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result word changed while stalled");

    // a fresh result follows a last byte taken earlier
    // (registered first into the input register, then into the result register)
    a_res_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(src_valid && !src_stall && src_data.last, 2))
        else $error("result without a preceding last byte");

    // input backpressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> res_valid && res_stall)
        else $error("input stalled while result side free");

endmodule

bind decimal_number_extract_sum dnes_checker u_dnes_checker (.*);
